// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the lexer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define CLEX_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies another one on the next clock edge.
`define CLEX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/clex_pkg.sv -----
`default_nettype none
package clex_pkg;

	localparam int unsigned Q_DEPTH = 4;
	localparam int unsigned Q_AW    = 2;
	localparam int unsigned Q_CW    = 3;

	localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
	localparam logic [1:0]  KW_RETURN = 2'b01;
	localparam logic [1:0]  KW_IF     = 2'b10;
	localparam logic [1:0]  KW_BOTH   = 2'b11;

	typedef enum logic [2:0] {
		MODE_IDLE    = 3'd0,
		MODE_PENDING = 3'd1,
		MODE_IDENT   = 3'd2,
		MODE_NUMBER  = 3'd3,
		MODE_ERROR   = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		PEND_LT  = 2'd0,
		PEND_GT  = 2'd1,
		PEND_EQ  = 2'd2,
		PEND_NOT = 2'd3
	} pend_t;

	typedef enum logic [2:0] {
		KIND_OPER   = 3'd0,
		KIND_IDENT  = 3'd1,
		KIND_NUMBER = 3'd2,
		KIND_RETURN = 3'd3,
		KIND_EOT    = 3'd4,
		KIND_ERROR  = 3'd5
	} kind_t;

	typedef enum logic [3:0] {
		OP_MUL    = 4'd0,
		OP_DIV    = 4'd1,
		OP_ADD    = 4'd2,
		OP_SUB    = 4'd3,
		OP_LPAREN = 4'd4,
		OP_RPAREN = 4'd5,
		OP_LE     = 4'd6,
		OP_GE     = 4'd7,
		OP_LT     = 4'd8,
		OP_GT     = 4'd9,
		OP_EQ     = 4'd10,
		OP_NE     = 4'd11,
		OP_ASSIGN = 4'd12,
		OP_SEMI   = 4'd13,
		OP_IF     = 4'd14
	} op_t;

	typedef struct packed {
		kind_t       kind;
		op_t         op;
		logic [15:0] start;
		logic [15:0] len;
		logic [30:0] val;
		logic        ovf;
		logic        last;
	} token_t;

	typedef struct packed {
		mode_t       mode;
		pend_t       pend;
		logic [15:0] pos;
		logic [15:0] tstart;
		logic [15:0] rlen;
		logic [30:0] acc;
		logic        sat;
		logic [1:0]  kwf;
	} state_t;

	function automatic state_t st_reset();
		state_t s;
		s        = '0;
		s.mode   = MODE_IDLE;
		s.pend   = PEND_LT;
		s.kwf    = KW_BOTH;
		return s;
	endfunction

	function automatic token_t make_tok(input kind_t kind, input op_t op,
			input logic [15:0] start, input logic [15:0] len,
			input logic [30:0] val, input logic ovf);
		token_t t;
		t.kind  = kind;
		t.op    = op;
		t.start = start;
		t.len   = len;
		t.val   = val;
		t.ovf   = ovf;
		t.last  = 1'b0;
		return t;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/c_subset_lexer_top.sv -----
// A byte accepted into the input register is lexed and queued once the token queue has room
// for two tokens, and its first token is then offered at the head of the queue.
// Throughput: one byte per cycle while the output is ready and each byte yields at most
// one token; a byte that yields two tokens takes two pops from the single-read token queue.
// Reset: arst_n clears the lexer to idle at offset zero and empties the token queue.
`default_nettype none
module c_subset_lexer_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // text_byte[7:0]
	input  wire logic [0:0]  s_tuser,  // end_of_text[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// operator_code[3:0], start_offset[19:4], token_length[35:20], number_value[66:36],
	// value_overflow[67], zero[71:68]
	output logic [71:0]      m_tdata,
	output logic [2:0]       m_tuser,  // token_kind[2:0]
	output logic             m_tlast
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eot_s1;
	logic             advance;
	logic             room2;
	clex_pkg::token_t tok0;
	clex_pkg::token_t tok1;
	logic [1:0]       tok_n;
	logic [1:0]       push_n;
	clex_pkg::token_t head;

	assign advance  = valid_s1 & room2;
	assign s_tready = ~valid_s1 | advance;
	assign push_n   = advance ? tok_n : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tuser[0];
		end
	end

	clex_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.text_byte (byte_s1),
		.eot       (eot_s1),
		.tok0      (tok0),
		.tok1      (tok1),
		.tok_n     (tok_n)
	);

	clex_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push0     (tok0),
		.push1     (tok1),
		.pop       (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room2     (room2)
	);

	assign m_tdata = {4'd0, head.ovf, head.val, head.len, head.start, head.op};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule
`default_nettype wire

// ----- rtl/core/clex_core.sv -----
`default_nettype none
`include "assert_macros.svh"
module clex_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [7:0]        text_byte,
	input  wire logic              eot,
	output clex_pkg::token_t       tok0,
	output clex_pkg::token_t       tok1,
	output logic [1:0]             tok_n
);

	typedef struct packed {
		clex_pkg::state_t st;
		logic             emit;
		clex_pkg::token_t tok;
	} idle_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [7:0] kw_return_char(input logic [2:0] i);
		logic [7:0] c;
		unique case (i)
			3'd0:    c = "r";
			3'd1:    c = "e";
			3'd2:    c = "t";
			3'd3:    c = "u";
			3'd4:    c = "r";
			3'd5:    c = "n";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] kw_if_char(input logic i);
		return i ? 8'("f") : 8'("i");
	endfunction

	function automatic clex_pkg::op_t single_op(input clex_pkg::pend_t p);
		clex_pkg::op_t o;
		unique case (p)
			clex_pkg::PEND_LT: o = clex_pkg::OP_LT;
			clex_pkg::PEND_GT: o = clex_pkg::OP_GT;
			clex_pkg::PEND_EQ: o = clex_pkg::OP_EQ;
			default:           o = clex_pkg::OP_NE;
		endcase
		return o;
	endfunction

	function automatic clex_pkg::op_t pair_op(input clex_pkg::pend_t p);
		clex_pkg::op_t o;
		unique case (p)
			clex_pkg::PEND_LT: o = clex_pkg::OP_LE;
			clex_pkg::PEND_GT: o = clex_pkg::OP_GE;
			clex_pkg::PEND_EQ: o = clex_pkg::OP_EQ;
			default:           o = clex_pkg::OP_NE;
		endcase
		return o;
	endfunction

	function automatic idle_t idle_byte(input logic [7:0] b, input logic [15:0] pos,
			input clex_pkg::state_t s);
		idle_t r;
		r.st      = s;
		r.st.mode = clex_pkg::MODE_IDLE;
		r.emit    = 1'b0;
		r.tok     = '0;
		priority if ((b >= 8'd9 && b <= 8'd13) || b == " ") begin
			r.emit = 1'b0;
		end else if (b == "*" || b == "/" || b == "+" || b == "-" || b == "(" ||
				b == ")" || b == ";") begin
			clex_pkg::op_t o;
			unique case (b)
				"*":     o = clex_pkg::OP_MUL;
				"/":     o = clex_pkg::OP_DIV;
				"+":     o = clex_pkg::OP_ADD;
				"-":     o = clex_pkg::OP_SUB;
				"(":     o = clex_pkg::OP_LPAREN;
				")":     o = clex_pkg::OP_RPAREN;
				default: o = clex_pkg::OP_SEMI;
			endcase
			r.emit = 1'b1;
			r.tok  = clex_pkg::make_tok(clex_pkg::KIND_OPER, o, pos, '0, '0, 1'b0);
		end else if (b == "<" || b == ">" || b == "=" || b == "!") begin
			r.st.mode   = clex_pkg::MODE_PENDING;
			r.st.pend   = (b == "<") ? clex_pkg::PEND_LT :
			              (b == ">") ? clex_pkg::PEND_GT :
			              (b == "=") ? clex_pkg::PEND_EQ : clex_pkg::PEND_NOT;
			r.st.tstart = pos;
		end else if (is_letter(b)) begin
			r.st.mode   = clex_pkg::MODE_IDENT;
			r.st.tstart = pos;
			r.st.rlen   = 16'd1;
			r.st.kwf    = ((b == "r") ? clex_pkg::KW_RETURN : 2'b00) |
			              ((b == "i") ? clex_pkg::KW_IF : 2'b00);
		end else if (is_digit(b)) begin
			r.st.mode   = clex_pkg::MODE_NUMBER;
			r.st.tstart = pos;
			r.st.acc    = {27'd0, b[3:0]};
			r.st.sat    = 1'b0;
		end else begin
			r.st.mode = clex_pkg::MODE_ERROR;
			r.emit    = 1'b1;
			r.tok     = clex_pkg::make_tok(clex_pkg::KIND_ERROR, clex_pkg::OP_MUL,
			                               pos, '0, '0, 1'b0);
		end
		return r;
	endfunction

	clex_pkg::state_t st_q;
	clex_pkg::state_t st_d;
	idle_t            id;
	logic             fa;
	logic             fb;
	clex_pkg::token_t ta;
	clex_pkg::token_t tb;
	logic             use_idle;
	logic [34:0]      acc_next;

	assign id       = idle_byte(text_byte, st_q.pos, st_q);
	assign acc_next = ({4'd0, st_q.acc} << 3) + ({4'd0, st_q.acc} << 1) +
	                  {31'd0, text_byte[3:0]};

	always_comb begin
		st_d     = st_q;
		fa       = 1'b0;
		ta       = '0;
		use_idle = 1'b0;
		if (eot) begin
			unique case (st_q.mode)
				clex_pkg::MODE_PENDING: begin
					fa = 1'b1;
					if (st_q.pend == clex_pkg::PEND_NOT) begin
						ta = clex_pkg::make_tok(clex_pkg::KIND_ERROR, clex_pkg::OP_MUL,
						                        st_q.tstart, '0, '0, 1'b0);
					end else begin
						ta = clex_pkg::make_tok(clex_pkg::KIND_OPER, single_op(st_q.pend),
						                        st_q.tstart, '0, '0, 1'b0);
					end
				end
				clex_pkg::MODE_IDENT: begin
					fa = 1'b1;
					ta = clex_pkg::make_tok(clex_pkg::KIND_IDENT, clex_pkg::OP_MUL,
					                        st_q.tstart, st_q.rlen, '0, 1'b0);
				end
				clex_pkg::MODE_NUMBER: begin
					fa = 1'b1;
					ta = clex_pkg::make_tok(clex_pkg::KIND_NUMBER, clex_pkg::OP_MUL,
					                        st_q.tstart, '0, st_q.acc, st_q.sat);
				end
				default: fa = 1'b0;
			endcase
			st_d = clex_pkg::st_reset();
		end else begin
			unique case (st_q.mode)
				clex_pkg::MODE_PENDING: begin
					fa = 1'b1;
					if (text_byte == "=") begin
						ta        = clex_pkg::make_tok(clex_pkg::KIND_OPER,
						                pair_op(st_q.pend), st_q.tstart, '0, '0, 1'b0);
						st_d.mode = clex_pkg::MODE_IDLE;
					end else if (st_q.pend == clex_pkg::PEND_NOT) begin
						ta        = clex_pkg::make_tok(clex_pkg::KIND_ERROR,
						                clex_pkg::OP_MUL, st_q.tstart, '0, '0, 1'b0);
						st_d.mode = clex_pkg::MODE_ERROR;
					end else begin
						ta       = clex_pkg::make_tok(clex_pkg::KIND_OPER,
						               single_op(st_q.pend), st_q.tstart, '0, '0, 1'b0);
						use_idle = 1'b1;
					end
				end
				clex_pkg::MODE_IDENT: begin
					priority if ((st_q.kwf & clex_pkg::KW_RETURN) != 2'b00 &&
							st_q.rlen < 16'd6 &&
							text_byte == kw_return_char(st_q.rlen[2:0])) begin
						st_d.rlen = st_q.rlen + 16'd1;
						if (st_q.rlen == 16'd5) begin
							fa        = 1'b1;
							ta        = clex_pkg::make_tok(clex_pkg::KIND_RETURN,
							                clex_pkg::OP_MUL, st_q.tstart, '0, '0, 1'b0);
							st_d.mode = clex_pkg::MODE_IDLE;
						end
					end else if ((st_q.kwf & clex_pkg::KW_IF) != 2'b00 &&
							st_q.rlen < 16'd2 &&
							text_byte == kw_if_char(st_q.rlen[0])) begin
						st_d.rlen = st_q.rlen + 16'd1;
						if (st_q.rlen == 16'd1) begin
							fa        = 1'b1;
							ta        = clex_pkg::make_tok(clex_pkg::KIND_OPER,
							                clex_pkg::OP_IF, st_q.tstart, '0, '0, 1'b0);
							st_d.mode = clex_pkg::MODE_IDLE;
						end
					end else if (is_letter(text_byte) || is_digit(text_byte)) begin
						st_d.kwf = 2'b00;
						if (st_q.rlen != 16'hFFFF) begin
							st_d.rlen = st_q.rlen + 16'd1;
						end
					end else begin
						fa       = 1'b1;
						ta       = clex_pkg::make_tok(clex_pkg::KIND_IDENT,
						               clex_pkg::OP_MUL, st_q.tstart, st_q.rlen, '0, 1'b0);
						use_idle = 1'b1;
					end
				end
				clex_pkg::MODE_NUMBER: begin
					if (is_digit(text_byte)) begin
						if (acc_next > {4'd0, clex_pkg::NUM_MAX}) begin
							st_d.acc = clex_pkg::NUM_MAX;
							st_d.sat = 1'b1;
						end else begin
							st_d.acc = acc_next[30:0];
						end
					end else begin
						fa       = 1'b1;
						ta       = clex_pkg::make_tok(clex_pkg::KIND_NUMBER,
						               clex_pkg::OP_MUL, st_q.tstart, '0, st_q.acc, st_q.sat);
						use_idle = 1'b1;
					end
				end
				clex_pkg::MODE_ERROR: begin
					fa = 1'b0;
				end
				default: begin
					use_idle = 1'b1;
				end
			endcase
			if (use_idle) begin
				st_d = id.st;
			end
			if (st_d.mode != clex_pkg::MODE_IDENT) begin
				st_d.kwf = clex_pkg::KW_BOTH;
			end
			st_d.pos = st_q.pos + 16'd1;
		end
	end

	always_comb begin
		if (eot) begin
			fb = 1'b1;
			tb = clex_pkg::make_tok(clex_pkg::KIND_EOT, clex_pkg::OP_MUL, st_q.pos,
			                        '0, '0, 1'b0);
		end else begin
			fb = use_idle & id.emit;
			tb = id.tok;
		end
	end

	always_comb begin
		tok0  = fa ? ta : tb;
		tok1  = tb;
		tok_n = {1'b0, fa} + {1'b0, fb};
		tok0.last = (tok_n == 2'd1);
		tok1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= clex_pkg::st_reset();
		end else if (en) begin
			st_q <= st_d;
		end
	end

	`CLEX_ASSERT(a_kwf_outside_ident, clk, arst_n, (st_q.mode != clex_pkg::MODE_IDENT) |-> (st_q.kwf == clex_pkg::KW_BOTH), "keyword flags not restored outside identifier")
	`CLEX_ASSERT_NEXT(a_eot_rewind, clk, arst_n, en && eot, st_q.pos == 16'd0 && st_q.mode == clex_pkg::MODE_IDLE, "end of text did not rewind the lexer")

endmodule
`default_nettype wire

// ----- rtl/core/clex_queue.sv -----
`default_nettype none
`include "assert_macros.svh"
module clex_queue (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic [1:0]                push_n,
	input  wire clex_pkg::token_t          push0,
	input  wire clex_pkg::token_t          push1,
	input  wire logic                      pop,
	output clex_pkg::token_t               head,
	output logic                           not_empty,
	output logic                           room2
);

	clex_pkg::token_t                   mem [clex_pkg::Q_DEPTH];
	logic [clex_pkg::Q_AW-1:0]          wp_q;
	logic [clex_pkg::Q_AW-1:0]          rp_q;
	logic [clex_pkg::Q_CW-1:0]          cnt_q;
	logic                               do_pop;

	assign not_empty = (cnt_q != '0);
	assign room2     = (cnt_q <= clex_pkg::Q_CW'(clex_pkg::Q_DEPTH - 2));
	assign head      = mem[rp_q];
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem[wp_q] <= push0;
		end
		if (push_n == 2'd2) begin
			mem[wp_q + clex_pkg::Q_AW'(1)] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + clex_pkg::Q_AW'(push_n);
			rp_q  <= rp_q + clex_pkg::Q_AW'(do_pop);
			cnt_q <= cnt_q + clex_pkg::Q_CW'(push_n) - clex_pkg::Q_CW'(do_pop);
		end
	end

	`CLEX_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= clex_pkg::Q_CW'(clex_pkg::Q_DEPTH), "token queue overfilled")
	`CLEX_ASSERT_NEXT(a_push_two, clk, arst_n, push_n == 2'd2 && !do_pop, cnt_q == $past(cnt_q) + clex_pkg::Q_CW'(2), "double push lost a token")

endmodule
`default_nettype wire

// ----- dv/tb_top.sv -----
`default_nettype none
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES  = 1_000_000;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_WORDS   = 95;
	localparam int LONG_IDENT    = 12;
	localparam int MAX_PRINTS    = 60;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // text_byte[7:0]
	logic [0:0]  s_tuser = '0;   // end_of_text[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [71:0] m_tdata;   // operator_code[3:0], start_offset[19:4], token_length[35:20],
	                        // number_value[66:36], value_overflow[67], zero[71:68]
	logic [2:0]  m_tuser;   // token_kind[2:0]
	logic        m_tlast;

	c_subset_lexer_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #1 clk = ~clk;

	logic [8:0]       text_words[$];
	clex_pkg::token_t expected_tokens[$];
	clex_pkg::token_t step_toks[$];
	int               words_queued = 0;
	int               errors = 0;
	int               tokens_seen = 0;
	int               cycles = 0;
	int               idle_pct = 0;
	int               stall_pct = 0;
	logic             in_fire = 1'b0;

	string      return_word = "return";
	string      if_word = "if";

	clex_pkg::mode_t lx_mode;
	clex_pkg::pend_t lx_pend;
	logic [15:0]     lx_pos;
	logic [15:0]     lx_tstart;
	logic [15:0]     lx_rlen;
	logic [30:0]     lx_acc;
	logic            lx_sat;
	logic [1:0]      lx_kwf;

	function automatic void lex_clear();
		lx_mode   = clex_pkg::MODE_IDLE;
		lx_pend   = clex_pkg::PEND_LT;
		lx_pos    = '0;
		lx_tstart = '0;
		lx_rlen   = '0;
		lx_acc    = '0;
		lx_sat    = 1'b0;
		lx_kwf    = clex_pkg::KW_BOTH;
	endfunction

	function automatic void add_tok(clex_pkg::kind_t k, clex_pkg::op_t o, logic [15:0] st,
			logic [15:0] ln, logic [30:0] v, logic ov);
		clex_pkg::token_t t;
		t.kind  = k;
		t.op    = o;
		t.start = st;
		t.len   = ln;
		t.val   = v;
		t.ovf   = ov;
		t.last  = 1'b0;
		step_toks.push_back(t);
	endfunction

	function automatic void emit_err(logic [15:0] st);
		lx_mode = clex_pkg::MODE_ERROR;
		add_tok(clex_pkg::KIND_ERROR, clex_pkg::OP_MUL, st, '0, '0, 1'b0);
	endfunction

	function automatic bit is_letter(logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit is_digit(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic clex_pkg::op_t lone_op(clex_pkg::pend_t pd);
		case (pd)
			clex_pkg::PEND_LT: return clex_pkg::OP_LT;
			clex_pkg::PEND_GT: return clex_pkg::OP_GT;
			clex_pkg::PEND_EQ: return clex_pkg::OP_EQ;
			default:           return clex_pkg::OP_NE;
		endcase
	endfunction

	function automatic clex_pkg::op_t pair_op(clex_pkg::pend_t pd);
		case (pd)
			clex_pkg::PEND_LT: return clex_pkg::OP_LE;
			clex_pkg::PEND_GT: return clex_pkg::OP_GE;
			clex_pkg::PEND_EQ: return clex_pkg::OP_EQ;
			default:           return clex_pkg::OP_NE;
		endcase
	endfunction

	function automatic void hold_op(clex_pkg::pend_t pd, logic [15:0] p);
		lx_mode   = clex_pkg::MODE_PENDING;
		lx_pend   = pd;
		lx_tstart = p;
	endfunction

	function automatic void begin_token(logic [7:0] b, logic [15:0] p);
		lx_mode = clex_pkg::MODE_IDLE;
		if ((b >= 8'd9 && b <= 8'd13) || b == " ")
			return;
		case (b)
			"*": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_MUL, p, '0, '0, 1'b0);
			"/": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_DIV, p, '0, '0, 1'b0);
			"+": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_ADD, p, '0, '0, 1'b0);
			"-": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_SUB, p, '0, '0, 1'b0);
			"(": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_LPAREN, p, '0, '0, 1'b0);
			")": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_RPAREN, p, '0, '0, 1'b0);
			";": add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_SEMI, p, '0, '0, 1'b0);
			"<": hold_op(clex_pkg::PEND_LT, p);
			">": hold_op(clex_pkg::PEND_GT, p);
			"=": hold_op(clex_pkg::PEND_EQ, p);
			"!": hold_op(clex_pkg::PEND_NOT, p);
			default: begin
				if (is_letter(b)) begin
					lx_mode   = clex_pkg::MODE_IDENT;
					lx_tstart = p;
					lx_rlen   = 16'd1;
					lx_kwf    = ((b == "r") ? clex_pkg::KW_RETURN : 2'b00) |
					            ((b == "i") ? clex_pkg::KW_IF : 2'b00);
				end else if (is_digit(b)) begin
					lx_mode   = clex_pkg::MODE_NUMBER;
					lx_tstart = p;
					lx_acc    = 31'(b - "0");
					lx_sat    = 1'b0;
				end else begin
					emit_err(p);
				end
			end
		endcase
	endfunction

	function automatic void lex_byte(logic eot, logic [7:0] b);
		logic [15:0]      p;
		logic [34:0]      v;
		clex_pkg::token_t t;
		int               n;
		p = lx_pos;
		step_toks.delete();
		if (eot) begin
			case (lx_mode)
				clex_pkg::MODE_PENDING: begin
					if (lx_pend == clex_pkg::PEND_NOT)
						add_tok(clex_pkg::KIND_ERROR, clex_pkg::OP_MUL, lx_tstart, '0, '0,
						        1'b0);
					else
						add_tok(clex_pkg::KIND_OPER, lone_op(lx_pend), lx_tstart, '0, '0,
						        1'b0);
				end
				clex_pkg::MODE_IDENT:
					add_tok(clex_pkg::KIND_IDENT, clex_pkg::OP_MUL, lx_tstart, lx_rlen, '0,
					        1'b0);
				clex_pkg::MODE_NUMBER:
					add_tok(clex_pkg::KIND_NUMBER, clex_pkg::OP_MUL, lx_tstart, '0, lx_acc,
					        lx_sat);
				default: ;
			endcase
			add_tok(clex_pkg::KIND_EOT, clex_pkg::OP_MUL, p, '0, '0, 1'b0);
			lex_clear();
		end else begin
			case (lx_mode)
				clex_pkg::MODE_PENDING: begin
					if (b == "=") begin
						add_tok(clex_pkg::KIND_OPER, pair_op(lx_pend), lx_tstart, '0, '0,
						        1'b0);
						lx_mode = clex_pkg::MODE_IDLE;
					end else if (lx_pend == clex_pkg::PEND_NOT) begin
						emit_err(lx_tstart);
					end else begin
						add_tok(clex_pkg::KIND_OPER, lone_op(lx_pend), lx_tstart, '0, '0,
						        1'b0);
						begin_token(b, p);
					end
				end
				clex_pkg::MODE_IDENT: begin
					if ((lx_kwf & clex_pkg::KW_RETURN) != 0 && lx_rlen < 16'd6 &&
							b == return_word[int'(lx_rlen)]) begin
						lx_rlen++;
						if (lx_rlen == 16'd6) begin
							add_tok(clex_pkg::KIND_RETURN, clex_pkg::OP_MUL, lx_tstart, '0,
							        '0, 1'b0);
							lx_mode = clex_pkg::MODE_IDLE;
						end
					end else if ((lx_kwf & clex_pkg::KW_IF) != 0 && lx_rlen < 16'd2 &&
							b == if_word[int'(lx_rlen)]) begin
						lx_rlen++;
						if (lx_rlen == 16'd2) begin
							add_tok(clex_pkg::KIND_OPER, clex_pkg::OP_IF, lx_tstart, '0, '0,
							        1'b0);
							lx_mode = clex_pkg::MODE_IDLE;
						end
					end else if (is_letter(b) || is_digit(b)) begin
						lx_kwf = 2'b00;
						if (lx_rlen != 16'hFFFF)
							lx_rlen++;
					end else begin
						lx_kwf = 2'b00;
						add_tok(clex_pkg::KIND_IDENT, clex_pkg::OP_MUL, lx_tstart, lx_rlen,
						        '0, 1'b0);
						begin_token(b, p);
					end
				end
				clex_pkg::MODE_NUMBER: begin
					if (is_digit(b)) begin
						v = 35'(lx_acc) * 35'd10 + 35'(b - "0");
						if (v > 35'(clex_pkg::NUM_MAX)) begin
							v      = 35'(clex_pkg::NUM_MAX);
							lx_sat = 1'b1;
						end
						lx_acc = v[30:0];
					end else begin
						add_tok(clex_pkg::KIND_NUMBER, clex_pkg::OP_MUL, lx_tstart, '0,
						        lx_acc, lx_sat);
						begin_token(b, p);
					end
				end
				clex_pkg::MODE_ERROR: ;
				default: begin_token(b, p);
			endcase
			if (lx_mode != clex_pkg::MODE_IDENT)
				lx_kwf = clex_pkg::KW_BOTH;
			lx_pos = lx_pos + 16'd1;
		end
		n = step_toks.size();
		for (int i = 0; i < n; i++) begin
			t = step_toks[i];
			t.last = (i == n - 1);
			expected_tokens.push_back(t);
		end
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("tb_top: token %0d %s: got %0h, want %0h", tokens_seen, what, got, want);
	endtask

	task automatic check_token();
		clex_pkg::token_t e;
		if (expected_tokens.size() == 0) begin
			report_mismatch("unexpected, kind", 32'(m_tuser), '0);
		end else begin
			e = expected_tokens.pop_front();
			if (m_tuser !== e.kind)
				report_mismatch("token_kind", 32'(m_tuser), 32'(e.kind));
			if (m_tdata[3:0] !== e.op)
				report_mismatch("operator_code", 32'(m_tdata[3:0]), 32'(e.op));
			if (m_tdata[19:4] !== e.start)
				report_mismatch("start_offset", 32'(m_tdata[19:4]), 32'(e.start));
			if (m_tdata[35:20] !== e.len)
				report_mismatch("token_length", 32'(m_tdata[35:20]), 32'(e.len));
			if (m_tdata[66:36] !== e.val)
				report_mismatch("number_value", 32'(m_tdata[66:36]), 32'(e.val));
			if (m_tdata[67] !== e.ovf)
				report_mismatch("value_overflow", 32'(m_tdata[67]), 32'(e.ovf));
			if (m_tlast !== e.last)
				report_mismatch("last_of_run", 32'(m_tlast), 32'(e.last));
		end
		tokens_seen++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready)
				lex_byte(s_tuser[0], s_tdata);
			if (m_tvalid && m_tready)
				check_token();
		end
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
		if (!s_tvalid || in_fire) begin
			if (text_words.size() > 0 && $urandom_range(99) >= idle_pct) begin
				s_tvalid <= 1'b1;
				{s_tuser, s_tdata} <= text_words.pop_front();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LIMIT_CYCLES) begin
			$display("tb_top: done, errors");
			$finish;
		end
	end

	task automatic push_byte(input logic [7:0] b);
		text_words.push_back({1'b0, b});
		words_queued++;
	endtask

	task automatic push_eot();
		text_words.push_back({1'b1, 8'($urandom_range(255))});
		words_queued++;
	endtask

	task automatic push_str(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	function automatic logic [7:0] rand_letter();
		if ($urandom_range(1) == 0)
			return 8'("a" + $urandom_range(25));
		return 8'("A" + $urandom_range(25));
	endfunction

	function automatic logic [7:0] rand_alnum();
		if ($urandom_range(3) == 0)
			return 8'("0" + $urandom_range(9));
		return rand_letter();
	endfunction

	function automatic logic [7:0] rand_space();
		int w;
		w = $urandom_range(8, 13);
		return (w == 8) ? 8'd32 : 8'(w);
	endfunction

	task automatic push_random_token();
		int    k;
		string ops;
		string cmp;
		ops = "*/+-();";
		cmp = "<>=!";
		case ($urandom_range(15))
			0: push_byte(ops[$urandom_range(6)]);
			1: begin
				k = $urandom_range(3);
				push_byte(cmp[k]);
				if ((k == 3) ? ($urandom_range(7) != 0) : ($urandom_range(1) == 0))
					push_byte("=");
			end
			2: push_str("return");
			3: push_str("if");
			4: begin
				case ($urandom_range(5))
					0: push_str("r");
					1: push_str("re");
					2: push_str("ret");
					3: push_str("retur");
					4: push_str("i");
					default: push_str("rn");
				endcase
				if ($urandom_range(1) == 0)
					push_byte(rand_alnum());
			end
			5, 6: begin
				push_byte(rand_letter());
				repeat ($urandom_range(7))
					push_byte(rand_alnum());
			end
			7, 8: begin
				repeat ($urandom_range(1, 11))
					push_byte(8'("0" + $urandom_range(9)));
			end
			9, 10, 11: begin
				repeat ($urandom_range(1, 2))
					push_byte(rand_space());
			end
			12: begin
				if ($urandom_range(3) == 0)
					push_byte(8'($urandom_range(255)));
				else
					push_byte(rand_space());
			end
			default: push_byte(ops[$urandom_range(6)]);
		endcase
	endtask

	task automatic queue_random_texts(input int count);
		int target;
		target = words_queued + count;
		while (words_queued < target) begin
			repeat ($urandom_range(12)) begin
				push_random_token();
				if ($urandom_range(2) == 0)
					push_byte(rand_space());
			end
			push_eot();
		end
	endtask

	task automatic wait_drained();
		while (text_words.size() > 0 || s_tvalid || expected_tokens.size() > 0)
			@(posedge clk);
	endtask

	task automatic run_phase(input int idle, input int stall);
		idle_pct  = idle;
		stall_pct = stall;
		queue_random_texts(PHASE_WORDS);
		wait_drained();
	endtask

	initial begin
		arst_n   = 1'b0;
		lex_clear();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_str("2147483648");
		push_eot();
		push_str("r!a");
		push_eot();
		push_byte(8'h00);
		push_byte(8'hFF);
		push_eot();
		push_str("<");
		push_eot();
		push_byte(8'hFF);
		push_eot();

		push_byte("x");
		repeat (LONG_IDENT - 1)
			push_byte(rand_alnum());
		push_str(" a1<=7");
		push_eot();

		run_phase(0, 0);
		run_phase(52, 0);
		run_phase(0, 52);
		run_phase(30, 30);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/clex_pkg.sv
rtl/core/clex_core.sv
rtl/core/clex_queue.sv
rtl/core/c_subset_lexer_top.sv
dv/tb_top.sv
